/* src/fixed_point_divide_saturating_macros.svh */
// assertion macros for the saturating fixed-point divider
`ifndef FIXED_POINT_DIVIDE_SATURATING_MACROS_SVH
`define FIXED_POINT_DIVIDE_SATURATING_MACROS_SVH

`ifndef ASSERT_OFF
// checked at every clock edge outside reset
`define FPDS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every clock edge, reset included
`define FPDS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FPDS_ASSERT(lbl, prop, msg)
`define FPDS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* src/fpds_pkg.sv */
package fpds_pkg;

  localparam int WORD_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int GUARD_SHIFT = 14;
  // quotient magnitude stays below 2^(GUARD_SHIFT + FRAC_BITS) when not clamped
  localparam int QUOT_BITS   = GUARD_SHIFT + FRAC_BITS;

  localparam logic [WORD_W-1:0] CLAMP_NEG = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] CLAMP_POS = {1'b0, {(WORD_W-1){1'b1}}};

  // one item in flight through the restoring divide stages
  typedef struct packed {
    logic [WORD_W-1:0]    rem;   // partial remainder, below ub unless sat is set
    logic [QUOT_BITS-1:0] qr;    // dividend bits still to shift in, quotient bits shifted out
    logic [WORD_W-1:0]    ub;    // absolute divisor
    logic                 neg;   // operand signs differ
    logic                 sat;   // clamp instead of divide
  } div_lane_t;

endpackage

/* src/fpds_if.sv */
interface fpds_in_if import fpds_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] dividend;
  logic signed [WORD_W-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface

interface fpds_out_if import fpds_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] quotient;
  logic                     saturated;

  modport source (output valid, output quotient, output saturated, input ready);
  modport sink   (input valid, input quotient, input saturated, output ready);
endinterface

/* src/fpds_div_stage.sv */
module fpds_div_stage import fpds_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      valid_i,
  input  div_lane_t lane_i,
  output logic      ready_o,
  output logic      valid_o,
  output div_lane_t lane_o,
  input  logic      ready_i
);

  logic            valid_r;
  div_lane_t       lane_r;
  div_lane_t       lane_nxt;
  logic [WORD_W:0] rem_sh;
  logic [WORD_W+1:0] diff;
  logic            take;

  // one restoring step: shift in the next dividend bit, subtract when it fits
  always_comb begin
    rem_sh   = {lane_i.rem, lane_i.qr[QUOT_BITS-1]};
    diff     = {1'b0, rem_sh} - {2'b00, lane_i.ub};
    take     = !diff[WORD_W+1];
    lane_nxt = lane_i;
    lane_nxt.rem = take ? diff[WORD_W-1:0] : rem_sh[WORD_W-1:0];
    lane_nxt.qr  = {lane_i.qr[QUOT_BITS-2:0], take};
  end

  // stage moves when empty or when the next stage takes its item
  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o) begin
      lane_r <= lane_nxt;
    end
  end

  assign valid_o = valid_r;
  assign lane_o  = lane_r;

endmodule

/* src/fixed_point_divide_saturating.sv */
// channel   dir  payload                              transfer when
// in_chan   in   dividend[31:0] s, divisor[31:0] s    valid && ready
// out_chan  out  quotient[31:0] s, saturated          valid && ready
//
// the path runs through absolute values, overflow guard, 30 restoring
// divide steps of one quotient bit each, and the sign fix into the output register.
// one operand pair enters every cycle while out_chan is not stalled; each stage holds one item.
// a stalled output fills bubbles behind it before in_chan.ready drops.
// rst_n is synchronous and clears all valid bits; in_chan.ready is low during reset.
`include "fixed_point_divide_saturating_macros.svh"

module fixed_point_divide_saturating import fpds_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  fpds_in_if.sink    in_chan,
  fpds_out_if.source out_chan
);

  // absolute value stage
  logic              a_valid_r;
  logic [WORD_W-1:0] a_ua_r;
  logic [WORD_W-1:0] a_ub_r;
  logic              a_neg_r;
  logic [WORD_W-1:0] a_ua_nxt;
  logic [WORD_W-1:0] a_ub_nxt;
  logic              a_ready;

  // guard stage
  logic              b_valid_r;
  div_lane_t         b_lane_r;
  div_lane_t         b_lane_nxt;
  logic [WORD_W-1:0] b_guard;
  logic              b_ready;

  // divide chain
  logic              div_valid [0:QUOT_BITS];
  div_lane_t         div_lane  [0:QUOT_BITS];
  logic              div_ready [0:QUOT_BITS];

  // output register
  logic              out_valid_r;
  logic [WORD_W-1:0] out_quot_r;
  logic              out_sat_r;
  logic [WORD_W-1:0] out_quot_nxt;
  logic [WORD_W-1:0] out_mag;
  logic              out_ready_int;

  // wrap-around absolute values
  always_comb begin
    a_ua_nxt = in_chan.dividend[WORD_W-1] ? (~in_chan.dividend + 1'b1) : in_chan.dividend;
    a_ub_nxt = in_chan.divisor[WORD_W-1]  ? (~in_chan.divisor + 1'b1)  : in_chan.divisor;
  end

  assign a_ready       = !a_valid_r || b_ready;
  assign in_chan.ready = rst_n && a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (a_ready) begin
      a_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_ua_r  <= a_ua_nxt;
      a_ub_r  <= a_ub_nxt;
      a_neg_r <= in_chan.dividend[WORD_W-1] ^ in_chan.divisor[WORD_W-1];
    end
  end

  // overflow guard and divider seed
  always_comb begin
    b_guard        = {{GUARD_SHIFT{a_ua_r[WORD_W-1]}}, a_ua_r[WORD_W-1:GUARD_SHIFT]};
    b_lane_nxt.sat = (b_guard >= a_ub_r);
    b_lane_nxt.rem = {{GUARD_SHIFT{1'b0}}, a_ua_r[WORD_W-1:GUARD_SHIFT]};
    b_lane_nxt.qr  = {a_ua_r[GUARD_SHIFT-1:0], {FRAC_BITS{1'b0}}};
    b_lane_nxt.ub  = a_ub_r;
    b_lane_nxt.neg = a_neg_r;
  end

  assign b_ready = !b_valid_r || div_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (b_ready) begin
      b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_lane_r <= b_lane_nxt;
    end
  end

  assign div_valid[0] = b_valid_r;
  assign div_lane[0]  = b_lane_r;

  // one quotient bit per stage
  for (genvar k = 0; k < QUOT_BITS; k++) begin : g_step
    fpds_div_stage u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (div_valid[k]),
      .lane_i  (div_lane[k]),
      .ready_o (div_ready[k]),
      .valid_o (div_valid[k+1]),
      .lane_o  (div_lane[k+1]),
      .ready_i (div_ready[k+1])
    );
  end

  assign div_ready[QUOT_BITS] = out_ready_int;

  // sign fix or clamp
  always_comb begin
    out_mag = {{(WORD_W-QUOT_BITS){1'b0}}, div_lane[QUOT_BITS].qr};
    if (div_lane[QUOT_BITS].sat) begin
      out_quot_nxt = div_lane[QUOT_BITS].neg ? CLAMP_NEG : CLAMP_POS;
    end else begin
      out_quot_nxt = div_lane[QUOT_BITS].neg ? (~out_mag + 1'b1) : out_mag;
    end
  end

  assign out_ready_int = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_ready_int) begin
      out_valid_r <= div_valid[QUOT_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready_int) begin
      out_quot_r <= out_quot_nxt;
      out_sat_r  <= div_lane[QUOT_BITS].sat;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.quotient  = out_quot_r;
  assign out_chan.saturated = out_sat_r;

  // checks
  `FPDS_ASSERT(a_sat_extreme, out_valid_r && out_sat_r |-> (out_quot_r == CLAMP_NEG || out_quot_r == CLAMP_POS), "clamped result is not an extreme value")
  `FPDS_ASSERT(a_quot_range, out_valid_r && !out_sat_r |-> (out_quot_r[WORD_W-1:QUOT_BITS] == '0 || out_quot_r[WORD_W-1:QUOT_BITS] == '1), "divided result out of range")
  `FPDS_ASSERT(a_seed_below_divisor, b_valid_r && !b_lane_r.sat |-> b_lane_r.rem < b_lane_r.ub, "divider seed not below divisor")
  `FPDS_ASSERT(a_tail_holds, div_valid[QUOT_BITS] && !out_ready_int |=> div_valid[QUOT_BITS], "last divide stage dropped a stalled item")
  `FPDS_ASSERT_ALWAYS(a_no_accept_in_reset, !rst_n |-> !in_chan.ready, "input ready during reset")

endmodule
